### hw/rtl/hns_pkg.sv
// ----------------------------------------------------------------------------
// hns_pkg
// Shared constants, register indexes and state types of the normal stencil.
// ----------------------------------------------------------------------------
package hns_pkg;

  localparam int MAX_WIDTH_DEF   = 2048;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_ROWS        = 4096;
  localparam int UP_WEIGHT       = 80;
  localparam int FRAC_SHIFT      = 32;
  localparam int ROOT_BITS       = 17;
  localparam int QUOT_BITS       = 2 * ROOT_BITS;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ABS,
    ST_SUM,
    ST_START,
    ST_NORM,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    NS_IDLE,
    NS_MUL,
    NS_DIV,
    NS_SQRT,
    NS_DONE
  } norm_state_e;

endpackage

### hw/rtl/hns_lines.sv
// ----------------------------------------------------------------------------
// hns_lines
// Upper and middle line buffers with synchronous (registered) read.
// ----------------------------------------------------------------------------
module hns_lines #(
  parameter int MAX_WIDTH   = hns_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = hns_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_next_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr_i,
  input  logic [SAMPLE_BITS-1:0]       mid_wr_data_i,
  input  logic [SAMPLE_BITS-1:0]       up_wr_data_i,
  output logic [SAMPLE_BITS-1:0]       mid_rd_o,
  output logic [SAMPLE_BITS-1:0]       mid_next_rd_o,
  output logic [SAMPLE_BITS-1:0]       up_rd_o
);
  import hns_pkg::*;

  logic [SAMPLE_BITS-1:0] mid_mem [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] up_mem  [MAX_WIDTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mid_mem[wr_addr_i] <= mid_wr_data_i;
    end
    if (rd_en_i) begin
      mid_rd_o      <= mid_mem[rd_addr_i];
      mid_next_rd_o <= mid_mem[rd_addr_next_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      up_mem[wr_addr_i] <= up_wr_data_i;
    end
    if (rd_en_i) begin
      up_rd_o <= up_mem[rd_addr_i];
    end
  end

endmodule

### hw/rtl/hns_norm.sv
// ----------------------------------------------------------------------------
// hns_norm
// Iterative unit magnitude: round(32768*v/sqrt(s)) saturated to 32767.
// Restoring division of v*v*2^32 by s, then a digit-serial square root.
// ----------------------------------------------------------------------------
module hns_norm #(
  parameter int SAMPLE_BITS = hns_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [SAMPLE_BITS-1:0]     mag_i,
  input  logic [2*SAMPLE_BITS+1:0]   sum_i,
  output logic                       done_o,
  output logic [14:0]                unit_o
);
  import hns_pkg::*;

  localparam int VW   = SAMPLE_BITS;
  localparam int SW   = 2 * SAMPLE_BITS + 2;
  localparam int NW   = 2 * SAMPLE_BITS + FRAC_SHIFT;
  localparam int RW   = SW + 1;
  localparam int SRW  = ROOT_BITS + 4;
  localparam int CNTW = $clog2(NW + 1);

  norm_state_e state_q, state_d;

  logic [VW-1:0]        v_q;
  logic [SW-1:0]        s_q;
  logic [NW-1:0]        num_q, num_d;
  logic [RW-1:0]        rem_q, rem_d;
  logic [QUOT_BITS-1:0] quo_q, quo_d;
  logic [SRW-1:0]       srem_q, srem_d;
  logic [ROOT_BITS-1:0] root_q, root_d;
  logic [CNTW-1:0]      cnt_q, cnt_d;

  logic [2*VW-1:0]      prod;
  logic [RW-1:0]        rem_sh;
  logic [SRW-1:0]       srem_sh;
  logic [SRW-1:0]       trial;
  logic [ROOT_BITS:0]   root_inc;

  assign prod     = v_q * v_q;
  assign rem_sh   = {rem_q[RW-2:0], num_q[NW-1]};
  assign srem_sh  = {srem_q[SRW-3:0], quo_q[QUOT_BITS-1 -: 2]};
  assign trial    = {2'b00, root_q, 2'b01};
  assign root_inc = {1'b0, root_q} + (ROOT_BITS+1)'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      NS_IDLE: if (start_i) state_d = NS_MUL;
      NS_MUL:  state_d = NS_DIV;
      NS_DIV:  if (cnt_q == CNTW'(NW - 1)) state_d = NS_SQRT;
      NS_SQRT: if (cnt_q == CNTW'(ROOT_BITS - 1)) state_d = NS_DONE;
      NS_DONE: state_d = NS_IDLE;
      default: state_d = NS_IDLE;
    endcase
  end

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    srem_d = srem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    unique case (state_q)
      NS_MUL: begin
        num_d = {prod, {FRAC_SHIFT{1'b0}}};
        rem_d = '0;
        quo_d = '0;
        cnt_d = '0;
      end
      NS_DIV: begin
        num_d = {num_q[NW-2:0], 1'b0};
        if (rem_sh >= {1'b0, s_q}) begin
          rem_d = rem_sh - {1'b0, s_q};
          quo_d = {quo_q[QUOT_BITS-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[QUOT_BITS-2:0], 1'b0};
        end
        if (cnt_q == CNTW'(NW - 1)) begin
          cnt_d  = '0;
          srem_d = '0;
          root_d = '0;
        end else begin
          cnt_d = cnt_q + CNTW'(1);
        end
      end
      NS_SQRT: begin
        quo_d = {quo_q[QUOT_BITS-3:0], 2'b00};
        if (srem_sh >= trial) begin
          srem_d = srem_sh - trial;
          root_d = {root_q[ROOT_BITS-2:0], 1'b1};
        end else begin
          srem_d = srem_sh;
          root_d = {root_q[ROOT_BITS-2:0], 1'b0};
        end
        cnt_d = cnt_q + CNTW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NS_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == NS_IDLE && start_i) begin
      v_q <= mag_i;
      s_q <= sum_i;
    end
    num_q  <= num_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    srem_q <= srem_d;
    root_q <= root_d;
  end

  // round half up: largest q with 2q-1 <= isqrt(quotient)
  assign done_o = (state_q == NS_DONE);
  assign unit_o = (root_inc[ROOT_BITS:1] > (ROOT_BITS)'(32767)) ? 15'h7fff
                                                                : root_inc[15:1];

endmodule

### hw/rtl/heightmap_normal_stencil.sv
// ----------------------------------------------------------------------------
// heightmap_normal_stencil
// Unit surface normals from a raster height map by central differences.
// ----------------------------------------------------------------------------
// Samples enter one at a time in raster order. Each input transaction yields
// zero to three normals (signed Q1.15): the pixel one row above it, and on the
// last row also the pixel to its left and, at the row end, the pixel itself.
// The block takes one sample at a time: it reads and updates the line buffers,
// then computes each normal with the bit-serial divider of the normalization
// unit (2*SAMPLE_BITS+32 steps) followed by its 17-step square root, and waits
// while the output is stalled.
// Writing a register restarts the frame at pixel (0,0). Line buffers need no
// clearing after reset.
// ----------------------------------------------------------------------------
module heightmap_normal_stencil #(
  parameter int MAX_WIDTH   = hns_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = hns_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] height_sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic signed [15:0] normal_z_o,
  output logic [10:0] pixel_column_o,
  output logic [11:0] pixel_row_o,
  output logic        last_of_run_o,
  output logic        end_of_frame_o
);
  import hns_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int SB = SAMPLE_BITS;
  localparam int SW = 2 * SAMPLE_BITS + 2;

  ctrl_state_e state_q, state_d;

  // Configuration and frame position
  logic [11:0]   width_q;
  logic [12:0]   height_q;
  logic [WW-1:0] w_eff;
  logic [12:0]   h_eff;
  logic [CW-1:0] col_q;
  logic [11:0]   row_q;
  logic          last_col, last_row, has_right;

  // Window of recent samples
  logic [SB-1:0] win0_q, win1_q, win2_q;
  logic [SB-1:0] x_q, x_in;

  // Line buffer read data
  logic [SB-1:0] mid_rd, mid_next_rd, up_rd;

  // Pending results of the current transaction
  logic signed [SB:0] res_dx_q [3];
  logic signed [SB:0] res_dz_q [3];
  logic [CW-1:0]      res_col_q [3];
  logic [11:0]        res_row_q [3];
  logic [2:0]         res_vld_q;
  logic [1:0]         sel;
  logic [2:0]         sel_hot;
  logic               sel_last;

  // Normalization datapath
  logic [SB-1:0]      mag_x_q, mag_z_q;
  logic               neg_x_q, neg_z_q;
  logic [SW-1:0]      sum_q;
  logic               norm_start;
  logic               done_x, done_y, done_z;
  logic [14:0]        unit_x, unit_y, unit_z;
  logic signed [SB:0] dx_sel, dz_sel;

  logic in_accept, out_accept, load;

  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  assign out_accept = (state_q == ST_OUT) && !out_stall_i;
  assign load       = (state_q == ST_LOAD);
  assign norm_start = (state_q == ST_START);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  // Clamp the registers to their usable ranges
  always_comb begin
    if (width_q == 12'd0) begin
      w_eff = WW'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == 13'd0) begin
      h_eff = 13'd1;
    end else if (height_q > 13'(MAX_ROWS)) begin
      h_eff = 13'(MAX_ROWS);
    end else begin
      h_eff = height_q;
    end
  end

  assign last_col  = ({1'b0, col_q} + WW'(1)) == w_eff;
  assign has_right = ({1'b0, col_q} + WW'(1)) <  w_eff;
  assign last_row  = ({1'b0, row_q} + 13'd1) == h_eff;
  assign x_in      = SB'(height_sample_i);

  hns_lines #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lines (
    .clk_i          (clk_i),
    .rd_en_i        (in_accept),
    .rd_addr_i      (col_q),
    .rd_addr_next_i (col_q + CW'(1)),
    .wr_en_i        (load),
    .wr_addr_i      (col_q),
    .mid_wr_data_i  (x_q),
    .up_wr_data_i   (mid_rd),
    .mid_rd_o       (mid_rd),
    .mid_next_rd_o  (mid_next_rd),
    .up_rd_o        (up_rd)
  );

  // Pick the lowest pending result; it is the last one if nothing is above it
  always_comb begin
    if (res_vld_q[0]) begin
      sel = 2'd0;
    end else if (res_vld_q[1]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
    sel_hot  = 3'b001 << sel;
    sel_last = (res_vld_q & ~sel_hot) == 3'b000;
  end

  assign dx_sel = res_dx_q[sel];
  assign dz_sel = res_dz_q[sel];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_accept) state_d = ST_LOAD;
      ST_LOAD:  begin
        // go on only if this sample completes at least one pixel
        if (row_q != 12'd0 || (last_row && (col_q != '0 || last_col))) begin
          state_d = ST_ABS;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ABS:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_START;
      ST_START: state_d = ST_NORM;
      ST_NORM:  if (done_x && done_y && done_z) state_d = ST_OUT;
      ST_OUT:   begin
        if (!out_stall_i) state_d = sel_last ? ST_IDLE : ST_ABS;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration, frame position and window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 12'd2048;
      height_q <= 13'd1;
      col_q    <= '0;
      row_q    <= '0;
      win0_q   <= '0;
      win1_q   <= '0;
      win2_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  width_q  <= cfg_wdata_i[11:0];
        CFG_FRAME_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
      // restart the frame
      col_q  <= '0;
      row_q  <= '0;
      win0_q <= '0;
      win1_q <= '0;
      win2_q <= '0;
    end else if (load) begin
      win2_q <= win1_q;
      win1_q <= x_q;
      win0_q <= mid_rd;
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? 12'd0 : row_q + 12'd1;
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= '0;
    end else if (load) begin
      res_vld_q[0] <= (row_q != 12'd0);
      res_vld_q[1] <= last_row && (col_q != '0);
      res_vld_q[2] <= last_row && last_col;
    end else if (out_accept) begin
      res_vld_q <= res_vld_q & ~sel_hot;
    end
  end

  // Build the three candidate stencils; off-map neighbors take the center
  always_ff @(posedge clk_i) begin
    logic [SB-1:0] l0, r0, u0, l1, u1, l2, u2;
    l0 = (col_q != '0) ? win0_q : mid_rd;
    r0 = has_right ? mid_next_rd : mid_rd;
    u0 = (row_q >= 12'd2) ? up_rd : mid_rd;
    l1 = (col_q >= CW'(2)) ? win2_q : win1_q;
    u1 = (row_q != 12'd0) ? win0_q : win1_q;
    l2 = (col_q != '0) ? win1_q : x_q;
    u2 = (row_q != 12'd0) ? mid_rd : x_q;
    if (in_accept) begin
      x_q <= x_in;
    end
    if (load) begin
      res_dx_q[0]  <= $signed({1'b0, l0}) - $signed({1'b0, r0});
      res_dz_q[0]  <= $signed({1'b0, u0}) - $signed({1'b0, x_q});
      res_col_q[0] <= col_q;
      res_row_q[0] <= row_q - 12'd1;
      res_dx_q[1]  <= $signed({1'b0, l1}) - $signed({1'b0, x_q});
      res_dz_q[1]  <= $signed({1'b0, u1}) - $signed({1'b0, win1_q});
      res_col_q[1] <= col_q - CW'(1);
      res_row_q[1] <= row_q;
      res_dx_q[2]  <= $signed({1'b0, l2}) - $signed({1'b0, x_q});
      res_dz_q[2]  <= $signed({1'b0, u2}) - $signed({1'b0, x_q});
      res_col_q[2] <= col_q;
      res_row_q[2] <= row_q;
    end
  end

  // Magnitudes, squared length, then three normalizers in parallel
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ABS) begin
      neg_x_q <= dx_sel[SB];
      neg_z_q <= dz_sel[SB];
      mag_x_q <= dx_sel[SB] ? SB'(-dx_sel) : dx_sel[SB-1:0];
      mag_z_q <= dz_sel[SB] ? SB'(-dz_sel) : dz_sel[SB-1:0];
    end
    if (state_q == ST_SUM) begin
      sum_q <= SW'(mag_x_q * mag_x_q) + SW'(mag_z_q * mag_z_q)
             + SW'(UP_WEIGHT * UP_WEIGHT);
    end
  end

  hns_norm #(.SAMPLE_BITS(SAMPLE_BITS)) u_norm_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .mag_i   (mag_x_q),
    .sum_i   (sum_q),
    .done_o  (done_x),
    .unit_o  (unit_x)
  );

  hns_norm #(.SAMPLE_BITS(SAMPLE_BITS)) u_norm_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .mag_i   (SB'(UP_WEIGHT)),
    .sum_i   (sum_q),
    .done_o  (done_y),
    .unit_o  (unit_y)
  );

  hns_norm #(.SAMPLE_BITS(SAMPLE_BITS)) u_norm_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .mag_i   (mag_z_q),
    .sum_i   (sum_q),
    .done_o  (done_z),
    .unit_o  (unit_z)
  );

  // Output register: loaded while normalizing, held until the normal is accepted
  always_ff @(posedge clk_i) begin
    if (state_q == ST_NORM) begin
      normal_x_o     <= neg_x_q ? -$signed({1'b0, unit_x}) : $signed({1'b0, unit_x});
      normal_y_o     <= $signed({1'b0, unit_y});
      normal_z_o     <= neg_z_q ? -$signed({1'b0, unit_z}) : $signed({1'b0, unit_z});
      pixel_column_o <= 11'(res_col_q[sel]);
      pixel_row_o    <= res_row_q[sel];
      last_of_run_o  <= sel_last;
      end_of_frame_o <= (sel == 2'd2);
    end
  end

endmodule
